// ===== hw/rtl/terminal_key_sequence_decoder_unit_assert.svh =====
// Assertion macros shared by the RTL of the key decoder.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_UNIT_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_UNIT_ASSERT_SVH

// Concurrent check on clk, off during reset.
`define TKSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tksd check failed");

// Implication check on clk, off during reset.
`define TKSD_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tksd check failed");

`endif

// ===== hw/rtl/tksd_pkg.sv =====
`default_nettype none
package tksd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ESC     = 2'd1,
    PH_BRACKET = 2'd2,
    PH_UTF8    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ESC      = 3'd0,
    KIND_ARROW_UP = 3'd1,
    KIND_ARROW_DN = 3'd2,
    KIND_ARROW_RT = 3'd3,
    KIND_ARROW_LT = 3'd4,
    KIND_NEWLINE  = 3'd5,
    KIND_ERASE    = 3'd6,
    KIND_GLYPH    = 3'd7
  } key_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    key_kind_t   key_kind;
    logic [2:0]  char_length;
    logic [31:0] char_bytes;
  } key_word_t;

  localparam logic        MODE_BYTE     = 1'b0;
  localparam logic        MODE_TICK     = 1'b1;
  localparam logic [7:0]  BYTE_ESC      = 8'd27;
  localparam logic [7:0]  BYTE_BRACKET  = 8'h5B;
  localparam logic [7:0]  BYTE_A        = 8'h41;
  localparam logic [7:0]  BYTE_B        = 8'h42;
  localparam logic [7:0]  BYTE_C        = 8'h43;
  localparam logic [7:0]  BYTE_D        = 8'h44;
  localparam logic [7:0]  BYTE_LF       = 8'd10;
  localparam logic [7:0]  BYTE_CR       = 8'd13;
  localparam logic [7:0]  BYTE_DEL      = 8'd127;
  localparam logic [7:0]  BYTE_BS       = 8'd8;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd10;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/terminal_key_sequence_decoder_unit.sv =====
`default_nettype none
// Decodes a stream of terminal bytes and time ticks into keys: ESC [ A/B/C/D
// arrows, escape (on a bad follow-up byte or after timeout_ticks ticks, one
// tick if it is zero), enter, backspace and UTF-8 characters of one to four
// bytes; a character cut short by the timeout comes out with length one and
// the bytes gathered. Words pass through the input and result registers;
// a new word is accepted every cycle while the key output is not stalled. The
// timeout register may be written only while no word is in flight.
module terminal_key_sequence_decoder_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  tksd_pkg::in_word_t  in_word,
  output logic                key_valid,
  input  wire                 key_stall,
  output tksd_pkg::key_word_t key_word,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [7:0]          cfg_data
);
  import tksd_pkg::*;

  logic [7:0]  timeout_ticks;
  logic        s1_valid;
  in_word_t    s1_word;
  logic        s1_fire;
  logic        out_free;

  phase_t      phase, phase_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [31:0] gathered_bytes, gathered_bytes_next;
  logic [2:0]  expected_length, expected_length_next;
  logic [2:0]  received_count, received_count_next;

  logic [7:0]  limit;
  logic [7:0]  wait_inc;
  logic        timed_out;
  logic [2:0]  lead_len;
  logic [2:0]  rc_inc;
  logic [31:0] merged_bytes;
  logic [7:0]  b;
  logic        emit;
  key_word_t   result;

  assign out_free  = !key_valid || !key_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign cfg_ready = !s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_word <= in_word;
    end
  end

  assign b        = s1_word.data_byte;
  assign limit    = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
  assign wait_inc = (wait_count == 8'hFF) ? wait_count : wait_count + 8'd1;
  assign timed_out = (wait_inc >= limit);
  assign lead_len = lead_length(b);
  assign rc_inc   = received_count + 3'd1;

  always_comb begin
    merged_bytes = gathered_bytes;
    unique case (received_count)
      3'd0:    merged_bytes[7:0]   = gathered_bytes[7:0]   | b;
      3'd1:    merged_bytes[15:8]  = gathered_bytes[15:8]  | b;
      3'd2:    merged_bytes[23:16] = gathered_bytes[23:16] | b;
      3'd3:    merged_bytes[31:24] = gathered_bytes[31:24] | b;
      default: merged_bytes = gathered_bytes;
    endcase
  end

  // next state
  always_comb begin
    phase_next           = phase;
    wait_count_next      = wait_count;
    gathered_bytes_next  = gathered_bytes;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    if (s1_fire) begin
      if (s1_word.mode == MODE_TICK) begin
        if (phase != PH_IDLE) begin
          wait_count_next = timed_out ? 8'd0 : wait_inc;
          if (timed_out) begin
            phase_next = PH_IDLE;
          end
        end
      end else begin
        wait_count_next = 8'd0;
        unique case (phase)
          PH_ESC: begin
            phase_next = (b == BYTE_BRACKET) ? PH_BRACKET : PH_IDLE;
          end
          PH_BRACKET: begin
            phase_next = PH_IDLE;
          end
          PH_UTF8: begin
            gathered_bytes_next = merged_bytes;
            received_count_next = rc_inc;
            if (rc_inc >= expected_length) begin
              phase_next = PH_IDLE;
            end
          end
          PH_IDLE: begin
            priority if (b == BYTE_ESC) begin
              phase_next = PH_ESC;
            end else if (b == BYTE_LF || b == BYTE_CR || b == BYTE_DEL || b == BYTE_BS) begin
              phase_next = PH_IDLE;
            end else begin
              gathered_bytes_next  = {24'd0, b};
              expected_length_next = lead_len;
              received_count_next  = 3'd1;
              phase_next           = (lead_len == 3'd1) ? PH_IDLE : PH_UTF8;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // result
  always_comb begin
    emit   = 1'b0;
    result = '{key_kind: KIND_ESC, char_length: 3'd0, char_bytes: 32'd0};
    if (s1_word.mode == MODE_TICK) begin
      if (phase != PH_IDLE && timed_out) begin
        emit = 1'b1;
        if (phase == PH_UTF8) begin
          result = '{key_kind: KIND_GLYPH, char_length: 3'd1, char_bytes: gathered_bytes};
        end
      end
    end else begin
      unique case (phase)
        PH_ESC: begin
          emit = (b != BYTE_BRACKET);
        end
        PH_BRACKET: begin
          emit = 1'b1;
          priority if (b == BYTE_A) begin
            result.key_kind = KIND_ARROW_UP;
          end else if (b == BYTE_B) begin
            result.key_kind = KIND_ARROW_DN;
          end else if (b == BYTE_C) begin
            result.key_kind = KIND_ARROW_RT;
          end else if (b == BYTE_D) begin
            result.key_kind = KIND_ARROW_LT;
          end else begin
            result.key_kind = KIND_ESC;
          end
        end
        PH_UTF8: begin
          emit = (rc_inc >= expected_length);
          result = '{key_kind: KIND_GLYPH, char_length: expected_length,
                     char_bytes: merged_bytes};
        end
        PH_IDLE: begin
          priority if (b == BYTE_ESC) begin
            emit = 1'b0;
          end else if (b == BYTE_LF || b == BYTE_CR) begin
            emit = 1'b1;
            result.key_kind = KIND_NEWLINE;
          end else if (b == BYTE_DEL || b == BYTE_BS) begin
            emit = 1'b1;
            result.key_kind = KIND_ERASE;
          end else begin
            emit = (lead_len == 3'd1);
            result = '{key_kind: KIND_GLYPH, char_length: 3'd1,
                       char_bytes: {24'd0, b}};
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_count      <= 8'd0;
      gathered_bytes  <= 32'd0;
      expected_length <= 3'd0;
      received_count  <= 3'd0;
    end else begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      gathered_bytes  <= gathered_bytes_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      key_valid <= 1'b1;
    end else if (!key_stall) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      key_word <= result;
    end
  end

`include "terminal_key_sequence_decoder_unit_assert.svh"

  `TKSD_ASSERT_IMP(a_idle_wait_clear, phase == PH_IDLE, wait_count == 8'd0)
  `TKSD_ASSERT_IMP(a_utf8_counts, phase == PH_UTF8,
                   expected_length >= 3'd2 && received_count < expected_length)
  `TKSD_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid && key_valid)
  `TKSD_ASSERT_IMP(a_non_char_empty, key_valid && key_word.key_kind != KIND_GLYPH,
                   key_word.char_length == 3'd0 && key_word.char_bytes == 32'd0)

endmodule
`default_nettype wire

// ===== tb/tb_terminal_key_sequence_decoder_unit.sv =====
`timescale 1ns / 100ps
module tb_terminal_key_sequence_decoder_unit;
  import tksd_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 4;
  localparam int PHASE_WORDS  = 380;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      key_valid;
  logic      key_stall = 1'b0;
  key_word_t key_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  terminal_key_sequence_decoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_word  (key_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // decoder shadow state
  logic [7:0]  timeout_reg  = TIMEOUT_RESET;
  phase_t      seq_phase    = PH_IDLE;
  logic [7:0]  ticks_waited = '0;
  logic [31:0] char_acc     = '0;
  logic [2:0]  char_need    = '0;
  logic [2:0]  char_got     = '0;

  in_word_t  pending_words[$];
  key_word_t expected_keys[$];

  int fail_count    = 0;
  int keys_checked  = 0;
  int words_sent    = 0;
  int items_queued  = 0;
  int settings_run  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int cycles        = 0;
  bit quiet         = 1'b0;

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_key(key_kind_t kind, logic [2:0] len, logic [31:0] bytes);
    key_word_t k;
    k.key_kind    = kind;
    k.char_length = len;
    k.char_bytes  = bytes;
    expected_keys.push_back(k);
    seq_phase    = PH_IDLE;
    ticks_waited = '0;
  endtask

  task automatic decode_word(in_word_t w);
    logic [7:0] limit;
    logic [7:0] b;
    b     = w.data_byte;
    limit = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
    if (w.mode == MODE_TICK) begin
      if (seq_phase != PH_IDLE) begin
        if (ticks_waited != 8'hFF) ticks_waited++;
        if (ticks_waited >= limit) begin
          if (seq_phase == PH_UTF8) push_key(KIND_GLYPH, 3'd1, char_acc);
          else push_key(KIND_ESC, 3'd0, '0);
        end
      end
    end else begin
      case (seq_phase)
        PH_ESC: begin
          if (b == BYTE_BRACKET) begin
            seq_phase    = PH_BRACKET;
            ticks_waited = '0;
          end else begin
            push_key(KIND_ESC, 3'd0, '0);
          end
        end
        PH_BRACKET: begin
          case (b)
            BYTE_A:  push_key(KIND_ARROW_UP, 3'd0, '0);
            BYTE_B:  push_key(KIND_ARROW_DN, 3'd0, '0);
            BYTE_C:  push_key(KIND_ARROW_RT, 3'd0, '0);
            BYTE_D:  push_key(KIND_ARROW_LT, 3'd0, '0);
            default: push_key(KIND_ESC, 3'd0, '0);
          endcase
        end
        PH_UTF8: begin
          // continuation bytes are taken as they come, ESC and newline too
          char_acc = char_acc | (32'(b) << (8 * char_got));
          char_got++;
          if (char_got >= char_need) push_key(KIND_GLYPH, char_need, char_acc);
          else ticks_waited = '0;
        end
        default: begin
          if (b == BYTE_ESC) begin
            seq_phase    = PH_ESC;
            ticks_waited = '0;
          end else if (b == BYTE_LF || b == BYTE_CR) begin
            push_key(KIND_NEWLINE, 3'd0, '0);
          end else if (b == BYTE_DEL || b == BYTE_BS) begin
            push_key(KIND_ERASE, 3'd0, '0);
          end else begin
            char_acc = {24'd0, b};
            char_got = 3'd1;
            if (!b[7]) char_need = 3'd1;
            else if (b[7:5] == 3'b110) char_need = 3'd2;
            else if (b[7:4] == 4'b1110) char_need = 3'd3;
            else if (b[7:3] == 5'b11110) char_need = 3'd4;
            else char_need = 3'd1;
            if (char_need == 3'd1) begin
              push_key(KIND_GLYPH, 3'd1, char_acc);
            end else begin
              seq_phase    = PH_UTF8;
              ticks_waited = '0;
            end
          end
        end
      endcase
    end
  endtask

  task automatic push_byte(logic [7:0] b);
    in_word_t w;
    w.mode      = MODE_BYTE;
    w.data_byte = b;
    pending_words.push_back(w);
    items_queued++;
  endtask

  task automatic push_ticks(int n);
    in_word_t w;
    repeat (n) begin
      w.mode      = MODE_TICK;
      w.data_byte = 8'($urandom);
      pending_words.push_back(w);
      items_queued++;
    end
  endtask

  function automatic int wait_limit();
    return (timeout_reg == 8'd0) ? 1 : int'(timeout_reg);
  endfunction

  // ticks that stay short of the timeout
  task automatic inner_ticks();
    int lim;
    int r;
    lim = wait_limit();
    r   = $urandom_range(0, 99);
    if (lim > 1 && r >= 60) begin
      if (r < 96) push_ticks($urandom_range(1, (lim - 1 < 3) ? lim - 1 : 3));
      else if (lim <= 20 || r == 99) push_ticks(lim - 1);
    end
  endtask

  function automatic bit give_up();
    return $urandom_range(0, 99) < ((wait_limit() <= 16) ? 12 : 2);
  endfunction

  task automatic time_out();
    push_ticks(wait_limit() + $urandom_range(0, 2));
  endtask

  task automatic gen_sequence();
    int r;
    int n;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      push_byte(BYTE_ESC);
      inner_ticks();
      if (give_up()) begin
        time_out();
      end else begin
        push_byte(BYTE_BRACKET);
        inner_ticks();
        if (give_up()) time_out();
        else push_byte(BYTE_A + 8'($urandom_range(0, 3)));
      end
    end else if (r < 35) begin
      push_byte(BYTE_ESC);
      inner_ticks();
      if ($urandom_range(0, 1)) push_byte(BYTE_BRACKET);
      push_byte(8'($urandom));
    end else if (r < 60) begin
      n = $urandom_range(1, 4);
      b = 8'($urandom);
      case (n)
        1:       b[7]   = 1'b0;
        2:       b[7:5] = 3'b110;
        3:       b[7:4] = 4'b1110;
        default: b[7:3] = 5'b11110;
      endcase
      push_byte(b);
      for (int i = 1; i < n; i++) begin
        inner_ticks();
        if (give_up()) begin
          time_out();
          break;
        end
        b = 8'($urandom);
        if ($urandom_range(0, 3) != 0) b[7:6] = 2'b10;
        push_byte(b);
      end
    end else if (r < 70) begin
      // stray continuation or a lead byte of no valid length
      b = 8'($urandom);
      if ($urandom_range(0, 1)) push_byte({2'b10, b[5:0]});
      else push_byte({5'b11111, b[2:0]});
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       push_byte(BYTE_LF);
        1:       push_byte(BYTE_CR);
        2:       push_byte(BYTE_DEL);
        default: push_byte(BYTE_BS);
      endcase
    end else if (r < 93) begin
      push_byte(8'($urandom));
    end else begin
      push_ticks($urandom_range(1, 3));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_keys.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_timeout(logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    timeout_reg = value;
    settings_run++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        decode_word(in_word);
        words_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        gap_left = (quiet || $urandom_range(0, 99) < 65) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : key_monitor
    key_word_t want;
    if (rst) begin
      key_stall <= 1'b0;
    end else begin
      if (key_valid && !key_stall) begin
        if (expected_keys.size() == 0) begin
          $error("key word with nothing pending: key_kind %0d", key_word.key_kind);
          fail_count++;
        end else begin
          want = expected_keys.pop_front();
          keys_checked++;
          if (key_word.key_kind !== want.key_kind) begin
            $error("key_kind: expected %0d, got %0d", want.key_kind, key_word.key_kind);
            fail_count++;
          end
          if (key_word.char_length !== want.char_length) begin
            $error("char_length: expected %0d, got %0d", want.char_length,
                   key_word.char_length);
            fail_count++;
          end
          if (key_word.char_bytes !== want.char_bytes) begin
            $error("char_bytes: expected %h, got %h", want.char_bytes, key_word.char_bytes);
            fail_count++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        key_stall <= 1'b1;
      end else if (quiet || $urandom_range(0, 99) < 75) begin
        key_stall <= 1'b0;
      end else begin
        stall_left = idle_len() - 1;
        key_stall <= 1'b1;
      end
    end
  end

  // stretches with no idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) quiet <= !quiet;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [7:0] settings[5];
    int phase_end;
    settings = '{8'd10, 8'd1, 8'd255, 8'd0, 8'd0};
    settings[4] = 8'($urandom_range(3, 40));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_timeout(8'd2);
    for (int k = 0; k < 4; k++) begin
      push_byte(BYTE_ESC);
      push_byte(BYTE_BRACKET);
      push_byte(BYTE_A + 8'(k));
    end
    push_byte(BYTE_ESC);
    push_byte(8'h78);
    push_byte(BYTE_LF);
    push_byte(BYTE_CR);
    push_byte(BYTE_DEL);
    push_byte(BYTE_BS);
    push_ticks(1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'hE2);
    push_byte(BYTE_ESC);
    push_byte(BYTE_LF);
    push_byte(8'hC3);
    push_ticks(2);
    push_byte(BYTE_ESC);
    push_ticks(2);

    foreach (settings[i]) begin
      settle();
      write_timeout(settings[i]);
      if (i < 2) hold_requests++;
      phase_end = items_queued + PHASE_WORDS;
      while (items_queued < phase_end) gen_sequence();
      // close out any open sequence before the next register write
      repeat (4) push_byte(BYTE_LF);
    end
    settle();

    $display("Checked %0d decoded keys from %0d input words", keys_checked, words_sent);
    $display("Covered %0d timeout settings incl. 0, 1 and 255, with long output holds",
             settings_run);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
